@@ hw/rtl/kvte_pkg.sv @@
// kvte_pkg: shared types and constants of the keyed value token extractor.
// No dependencies; imported by every kvte module.
package kvte_pkg;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_NAME   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LENGTH = 1'b1;

  localparam int KEY_NAME_W = 64;
  localparam int KEY_LEN_W  = 4;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 4'd2;

  localparam int VLEN_W = 5;  // value_length field width

  // characters
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // per-message summary handed from front to back
  typedef struct packed {
    logic found;
    logic by_q;
    logic bank;
  } msg_info_t;

  localparam int MSG_INFO_W = $bits(msg_info_t);

  // value bank handed back once its last byte has been read out
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  function automatic logic is_stop(input logic [7:0] b);
    return (b == CH_AMP) || (b == CH_SEMI) || (b == CH_SPACE) ||
           (b == CH_NUL) || (b == CH_LF);
  endfunction

endpackage

@@ hw/rtl/kvte_front.sv @@
// kvte_front: key registers, byte window, key pattern match and value capture.
// Depends on kvte_pkg. Writes value bytes into the banked stores of kvte_back.
module kvte_front import kvte_pkg::*; #(
  parameter int MAX_VALUE_LEN = 29,
  parameter int MAX_KEY_LEN   = 8,
  localparam int CW = $clog2(MAX_VALUE_LEN + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [KEY_NAME_W-1:0] cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tlast,
  // value store write side
  output logic                  amp_we,
  output logic                  q_we,
  output logic                  wr_bank,
  output logic [CW-1:0]         amp_wr_idx,
  output logic [CW-1:0]         q_wr_idx,
  output logic [7:0]            wr_data,
  // descriptor push
  output logic                  desc_push,
  output msg_info_t             desc_info,
  output logic [CW-1:0]         desc_cnt,
  input  logic                  desc_full,
  input  bank_rel_t             bank_rel
);

  localparam int LW = $clog2(MAX_KEY_LEN + 1);

  logic [KEY_NAME_W-1:0] key_name_r;
  logic [KEY_LEN_W-1:0]  key_length_r;

  logic [7:0]    recent_r [MAX_KEY_LEN+1];
  logic [7:0]    recent_nxt [MAX_KEY_LEN+1];
  logic          amp_matched_r, amp_matched_nxt;
  logic          amp_cap_r, amp_cap_nxt;
  logic [CW-1:0] amp_cnt_r, amp_cnt_nxt;
  logic          q_matched_r, q_matched_nxt;
  logic          q_cap_r, q_cap_nxt;
  logic [CW-1:0] q_cnt_r, q_cnt_nxt;
  logic          text_ended_r, text_ended_nxt;
  logic          cur_bank_r;
  logic [1:0]    busy_r, busy_nxt;

  logic                 accept;
  logic [LW-1:0]        len_eff;
  logic [MAX_KEY_LEN:0] amp_hit_l, q_hit_l;
  logic                 amp_pat, q_pat;

  // stepped per-message values before the end-of-message clear
  logic          s_amp_m, s_amp_c, s_q_m, s_q_c, s_end;
  logic [CW-1:0] s_amp_n, s_q_n;

  assign in_tready = !busy_r[cur_bank_r] && !desc_full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_name_r   <= '0;
      key_length_r <= KEY_LEN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_KEY_NAME:   key_name_r   <= cfg_wr_data;
        REG_KEY_LENGTH: key_length_r <= cfg_wr_data[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff = (key_length_r > KEY_LEN_W'(MAX_KEY_LEN)) ? LW'(MAX_KEY_LEN)
                                                            : LW'(key_length_r);

  // One compare set per possible key length; slot 0 holds the previous byte.
  always_comb begin
    logic body_ok;
    for (int l = 0; l <= MAX_KEY_LEN; l++) begin
      body_ok = 1'b1;
      for (int j = 1; j <= l; j++) begin
        body_ok = body_ok && (recent_r[j-1] == key_name_r[8*(l-j) +: 8]);
      end
      amp_hit_l[l] = body_ok && (in_tdata == CH_EQ) && (recent_r[l] == CH_AMP);
      q_hit_l[l]   = body_ok && (in_tdata == CH_EQ) && (recent_r[l] == CH_QMARK);
    end
  end

  assign amp_pat = amp_hit_l[len_eff];
  assign q_pat   = q_hit_l[len_eff];

  assign wr_bank    = cur_bank_r;
  assign amp_wr_idx = amp_cnt_r;
  assign q_wr_idx   = q_cnt_r;
  assign wr_data    = in_tdata;

  always_comb begin
    s_amp_m = amp_matched_r;
    s_amp_c = amp_cap_r;
    s_amp_n = amp_cnt_r;
    s_q_m   = q_matched_r;
    s_q_c   = q_cap_r;
    s_q_n   = q_cnt_r;
    s_end   = text_ended_r;
    amp_we  = 1'b0;
    q_we    = 1'b0;
    for (int i = 0; i <= MAX_KEY_LEN; i++) recent_nxt[i] = recent_r[i];

    if (accept && !text_ended_r) begin
      if (in_tdata == CH_NUL) begin
        s_end   = 1'b1;
        s_amp_c = 1'b0;
        s_q_c   = 1'b0;
      end else begin
        if (amp_cap_r) begin
          if (is_stop(in_tdata) || amp_cnt_r >= CW'(MAX_VALUE_LEN)) begin
            s_amp_c = 1'b0;
          end else begin
            amp_we  = 1'b1;
            s_amp_n = amp_cnt_r + 1'b1;
            if (s_amp_n >= CW'(MAX_VALUE_LEN)) s_amp_c = 1'b0;
          end
        end
        if (q_cap_r) begin
          if (is_stop(in_tdata) || q_cnt_r >= CW'(MAX_VALUE_LEN)) begin
            s_q_c = 1'b0;
          end else begin
            q_we  = 1'b1;
            s_q_n = q_cnt_r + 1'b1;
            if (s_q_n >= CW'(MAX_VALUE_LEN)) s_q_c = 1'b0;
          end
        end
        recent_nxt[0] = in_tdata;
        for (int i = 1; i <= MAX_KEY_LEN; i++) recent_nxt[i] = recent_r[i-1];
        if (!amp_matched_r && amp_pat) begin
          s_amp_m = 1'b1;
          s_amp_c = 1'b1;
        end
        if (!q_matched_r && q_pat) begin
          s_q_m = 1'b1;
          s_q_c = 1'b1;
        end
      end
    end

    desc_push       = accept && in_tlast;
    desc_info.found = s_amp_m || s_q_m;
    desc_info.by_q  = !s_amp_m && s_q_m;
    desc_info.bank  = cur_bank_r;
    desc_cnt        = s_amp_m ? s_amp_n : (s_q_m ? s_q_n : '0);

    amp_matched_nxt = s_amp_m;
    amp_cap_nxt     = s_amp_c;
    amp_cnt_nxt     = s_amp_n;
    q_matched_nxt   = s_q_m;
    q_cap_nxt       = s_q_c;
    q_cnt_nxt       = s_q_n;
    text_ended_nxt  = s_end;
    if (desc_push) begin
      amp_matched_nxt = 1'b0;
      amp_cap_nxt     = 1'b0;
      amp_cnt_nxt     = '0;
      q_matched_nxt   = 1'b0;
      q_cap_nxt       = 1'b0;
      q_cnt_nxt       = '0;
      text_ended_nxt  = 1'b0;
      for (int i = 0; i <= MAX_KEY_LEN; i++) recent_nxt[i] = '0;
    end

    busy_nxt = busy_r;
    if (bank_rel.valid) busy_nxt[bank_rel.bank] = 1'b0;
    if (desc_push)      busy_nxt[cur_bank_r]    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_KEY_LEN; i++) recent_r[i] <= '0;
      amp_matched_r <= 1'b0;
      amp_cap_r     <= 1'b0;
      amp_cnt_r     <= '0;
      q_matched_r   <= 1'b0;
      q_cap_r       <= 1'b0;
      q_cnt_r       <= '0;
      text_ended_r  <= 1'b0;
      cur_bank_r    <= 1'b0;
      busy_r        <= '0;
    end else begin
      for (int i = 0; i <= MAX_KEY_LEN; i++) recent_r[i] <= recent_nxt[i];
      amp_matched_r <= amp_matched_nxt;
      amp_cap_r     <= amp_cap_nxt;
      amp_cnt_r     <= amp_cnt_nxt;
      q_matched_r   <= q_matched_nxt;
      q_cap_r       <= q_cap_nxt;
      q_cnt_r       <= q_cnt_nxt;
      text_ended_r  <= text_ended_nxt;
      busy_r        <= busy_nxt;
      if (desc_push) cur_bank_r <= !cur_bank_r;
    end
  end

endmodule

@@ hw/rtl/kvte_desc_fifo.sv @@
// kvte_desc_fifo: two-entry queue of per-message descriptors, front to back.
// Depends on kvte_pkg only for the common import style.
module kvte_desc_fifo import kvte_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] head_data
);

  logic [DW-1:0] entry_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;

  assign full      = (count_r == 2'd2);
  assign valid     = (count_r != 2'd0);
  assign head_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ hw/rtl/kvte_back.sv @@
// kvte_back: banked value stores, read sequencer and output register.
// Depends on kvte_pkg. Fed by kvte_front writes and kvte_desc_fifo.
module kvte_back import kvte_pkg::*; #(
  parameter int MAX_VALUE_LEN = 29,
  localparam int CW = $clog2(MAX_VALUE_LEN + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              amp_we,
  input  logic              q_we,
  input  logic              wr_bank,
  input  logic [CW-1:0]     amp_wr_idx,
  input  logic [CW-1:0]     q_wr_idx,
  input  logic [7:0]        wr_data,
  input  logic              desc_valid,
  input  msg_info_t         desc_info,
  input  logic [CW-1:0]     desc_cnt,
  output logic              desc_pop,
  output bank_rel_t         bank_rel,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  localparam int DEPTH = 2 * MAX_VALUE_LEN;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0] amp_mem [DEPTH];
  logic [7:0] q_mem   [DEPTH];
  logic [7:0] amp_rd_r, q_rd_r;

  logic [CW-1:0] k_r;
  logic          s1_valid_r, s1_bv_r, s1_found_r, s1_byq_r, s1_last_r;
  logic [CW-1:0] s1_len_r;

  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_bv_r, out_found_r, out_byq_r, out_last_r;
  logic [VLEN_W-1:0] out_len_r;

  logic          out_adv, s1_en, issue, is_last, empty_msg;
  logic [AW-1:0] amp_wr_addr, q_wr_addr, rd_addr;

  assign amp_wr_addr = (wr_bank ? AW'(MAX_VALUE_LEN) : AW'(0)) + AW'(amp_wr_idx);
  assign q_wr_addr   = (wr_bank ? AW'(MAX_VALUE_LEN) : AW'(0)) + AW'(q_wr_idx);
  assign rd_addr     = (desc_info.bank ? AW'(MAX_VALUE_LEN) : AW'(0)) + AW'(k_r);

  assign out_adv   = !out_valid_r || out_tready;
  assign s1_en     = !s1_valid_r || out_adv;
  assign issue     = desc_valid && s1_en;
  assign empty_msg = (desc_cnt == '0);
  assign is_last   = empty_msg || (CW'(k_r + 1'b1) == desc_cnt);
  assign desc_pop  = issue && is_last;

  assign bank_rel.valid = desc_pop;
  assign bank_rel.bank  = desc_info.bank;

  always_ff @(posedge clk) begin
    if (amp_we) amp_mem[amp_wr_addr] <= wr_data;
    if (q_we)   q_mem[q_wr_addr]     <= wr_data;
    if (issue) begin
      amp_rd_r <= amp_mem[rd_addr];
      q_rd_r   <= q_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_bv_r    <= !empty_msg;
      s1_found_r <= desc_info.found;
      s1_byq_r   <= desc_info.by_q;
      s1_last_r  <= is_last;
      s1_len_r   <= desc_cnt;
    end
    if (out_adv && s1_valid_r) begin
      out_byte_r  <= s1_bv_r ? (s1_byq_r ? q_rd_r : amp_rd_r) : 8'h00;
      out_bv_r    <= s1_bv_r;
      out_found_r <= s1_found_r;
      out_byq_r   <= s1_byq_r;
      out_last_r  <= s1_last_r;
      out_len_r   <= VLEN_W'(s1_len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) k_r <= is_last ? '0 : CW'(k_r + 1'b1);
      if (s1_en)   s1_valid_r  <= issue;
      if (out_adv) out_valid_r <= s1_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_len_r, out_byte_r};
  assign out_tuser  = {out_byq_r, out_found_r, out_bv_r};
  assign out_tlast  = out_last_r;

endmodule

@@ hw/rtl/keyed_value_token_extractor_unit.sv @@
// keyed_value_token_extractor_unit: top level of the keyed value extractor.
// Depends on kvte_pkg, kvte_front, kvte_desc_fifo and kvte_back.
//
//  channel | dir | handshake            | word contents
//  --------+-----+----------------------+---------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata[7:0] message byte, tlast end of message
//  out_    | out | out_tvalid/out_tready| tdata value byte + length, tuser flags, tlast
//  cfg_    | in  | cfg_wr_en only       | addr 0 key name, addr 1 key length
//
// Cycles: one message byte is taken per clock while in_tready is high. Matching is
// one set of parallel compares against the byte window, so there is no per-byte loop.
// At end of message the back end plays out one result word per clock, while out_tready
// is high, from the value store of that message (a read stage, then the output register).
// Two value banks: the front fills one bank while the back drains the other.
// in_tready drops only if the front needs a bank the back has not drained yet,
// i.e. when a message ends while the back still holds the message before it.
// Reset: synchronous, active low; clears control state and the key name, and sets the key length to 2.
// Value stores are not cleared; only bytes written in the same message are read.
module keyed_value_token_extractor_unit import kvte_pkg::*; #(
  parameter int MAX_VALUE_LEN = 29,
  parameter int MAX_KEY_LEN   = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [KEY_NAME_W-1:0] cfg_wr_data,
  // message words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] message_byte
  input  logic                  in_tlast,   // end_of_message
  // result words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [7:0] value_byte, [12:8] value_length
  output logic [2:0]            out_tuser,  // [0] byte_valid, [1] found, [2] found_by_question
  output logic                  out_tlast   // last_of_run
);

  localparam int CW = $clog2(MAX_VALUE_LEN + 1);
  localparam int DW = MSG_INFO_W + CW;

  logic          amp_we, q_we, wr_bank;
  logic [CW-1:0] amp_wr_idx, q_wr_idx;
  logic [7:0]    wr_data;

  logic          desc_push, desc_full, desc_pop, desc_valid;
  msg_info_t     push_info, head_info;
  logic [CW-1:0] push_cnt, head_cnt;
  logic [DW-1:0] head_data;
  bank_rel_t     bank_rel;

  // front: window, key match, capture into the current bank
  kvte_front #(
    .MAX_VALUE_LEN (MAX_VALUE_LEN),
    .MAX_KEY_LEN   (MAX_KEY_LEN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .amp_we      (amp_we),
    .q_we        (q_we),
    .wr_bank     (wr_bank),
    .amp_wr_idx  (amp_wr_idx),
    .q_wr_idx    (q_wr_idx),
    .wr_data     (wr_data),
    .desc_push   (desc_push),
    .desc_info   (push_info),
    .desc_cnt    (push_cnt),
    .desc_full   (desc_full),
    .bank_rel    (bank_rel)
  );

  // one descriptor per finished message
  kvte_desc_fifo #(
    .DW (DW)
  ) u_desc_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .push_data ({push_info, push_cnt}),
    .full      (desc_full),
    .pop       (desc_pop),
    .valid     (desc_valid),
    .head_data (head_data)
  );

  assign head_info = head_data[DW-1 -: MSG_INFO_W];
  assign head_cnt  = head_data[CW-1:0];

  // back: reads the chosen value out, one word per clock while out_tready is high
  kvte_back #(
    .MAX_VALUE_LEN (MAX_VALUE_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .amp_we     (amp_we),
    .q_we       (q_we),
    .wr_bank    (wr_bank),
    .amp_wr_idx (amp_wr_idx),
    .q_wr_idx   (q_wr_idx),
    .wr_data    (wr_data),
    .desc_valid (desc_valid),
    .desc_info  (head_info),
    .desc_cnt   (head_cnt),
    .desc_pop   (desc_pop),
    .bank_rel   (bank_rel),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
